/* rtl/thread_scheduler_four_policy_defines.svh */
// Assertion macros for the thread scheduler checker.
// No dependencies.
`ifndef THREAD_SCHEDULER_FOUR_POLICY_DEFINES_SVH
`define THREAD_SCHEDULER_FOUR_POLICY_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/tsfp_pkg.sv */
// Package for the thread scheduler: slot states, policies, controller states, command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package tsfp_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int MAIN_LIFETIME_DEF = 65535;
    localparam int MAIN_PRIORITY_DEF = 0;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0, ST_READY = 2'd1, ST_RUN = 2'd2, ST_TERM = 2'd3
    } t_slot_state;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0, POL_RR = 2'd1, POL_PRIO = 2'd2, POL_SJF = 2'd3
    } t_policy;

    typedef enum logic [3:0] {
        S_IDLE, S_CREATE, S_TICK, S_SCAN, S_DECIDE, S_START, S_REPORT, S_OUT
    } t_ctrl_state;

    typedef struct packed {
        logic load;        // latch request
        logic do_create;
        logic do_tick;     // first tick step: retire current
        logic scan_clear;
        logic scan_step;
        logic decide;
        logic start;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic tick_active;
        logic scan_done;
    } t_status;
endpackage

/* rtl/tsfp_if.sv */
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on nothing.
`timescale 1ns / 1ps
interface tsfp_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] new_tid;
    logic [15:0] new_lifetime;
    logic [7:0] new_priority;
    modport source(output valid, kind, new_tid, new_lifetime, new_priority, input ready);
    modport sink(input valid, kind, new_tid, new_lifetime, new_priority, output ready);
endinterface

interface tsfp_rsp_if;
    logic       valid;
    logic       ready;
    logic       create_accepted;
    logic       switched;
    logic       from_main;
    logic [7:0] from_tid;
    logic       to_main;
    logic [7:0] to_tid;
    logic       ended_valid;
    logic [7:0] ended_tid;
    logic       all_done;
    logic [4:0] live_count;
    modport source(output valid, create_accepted, switched, from_main, from_tid, to_main,
                   to_tid, ended_valid, ended_tid, all_done, live_count, input ready);
    modport sink(input valid, create_accepted, switched, from_main, from_tid, to_main,
                 to_tid, ended_valid, ended_tid, all_done, live_count, output ready);
endinterface

interface tsfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

/* rtl/tsfp_ctrl.sv */
// Controller state machine of the thread scheduler.
// Depends on tsfp_pkg.
`timescale 1ns / 1ps
module tsfp_ctrl
    import tsfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_req_valid) n_state = S_CREATE;
            S_CREATE: begin
                if (!i_status.kind) n_state = S_REPORT;
                else if (i_status.tick_active) n_state = S_TICK;
                else n_state = S_REPORT;
            end
            S_TICK:   n_state = S_SCAN;
            S_SCAN:   if (i_status.scan_done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_START;
            S_START:  n_state = S_REPORT;
            S_REPORT: if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load = i_req_valid;
            end
            S_CREATE: begin
                o_cmd.do_create = !i_status.kind;
                o_cmd.scan_clear = 1'b1;
            end
            S_TICK:   o_cmd.do_tick = 1'b1;
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_DECIDE: o_cmd.decide = 1'b1;
            S_START:  o_cmd.start = 1'b1;
            S_REPORT: o_cmd.report = i_out_free;
            default:  o_cmd = '0;
        endcase
    end
endmodule

/* rtl/tsfp_dp.sv */
// Datapath of the thread scheduler: slot table, serial pick scan, result register.
// Depends on tsfp_pkg.
`timescale 1ns / 1ps
module tsfp_dp
    import tsfp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int MAIN_LIFETIME = MAIN_LIFETIME_DEF,
    parameter int MAIN_PRIORITY = MAIN_PRIORITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [1:0] i_policy,
    input  logic       i_kind,
    input  logic [7:0] i_new_tid,
    input  logic [15:0] i_new_lifetime,
    input  logic [7:0] i_new_priority,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic       o_create_accepted,
    output logic       o_switched,
    output logic       o_from_main,
    output logic [7:0] o_from_tid,
    output logic       o_to_main,
    output logic [7:0] o_to_tid,
    output logic       o_ended_valid,
    output logic [7:0] o_ended_tid,
    output logic       o_all_done,
    output logic [4:0] o_live_count
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    t_slot_state r_st [SLOTS];
    logic [7:0]  r_id [SLOTS];
    logic [15:0] r_life [SLOTS];
    logic [7:0]  r_prio [SLOTS];
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_run;
    logic        r_done;

    logic        r_kind;
    logic [7:0]  r_tid;
    logic [15:0] r_nlife;
    logic [7:0]  r_nprio;
    logic [SW-1:0] r_from;
    logic        r_ended;
    logic        r_acc;
    logic        r_term_other;   // non-rr current terminated
    logic        r_main_pick;    // non-rr, main was running
    logic        r_rr;
    logic [SW-1:0] r_idx;
    logic [CW-1:0] r_step;
    logic        r_found;
    logic [SW-1:0] r_best;
    logic        r_start_ok;
    logic        r_go_main;

    // lowest empty slot for create
    logic        free_hit;
    logic [SW-1:0] free_idx;
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 1; i--) begin
            if (r_st[i] == ST_EMPTY) begin
                free_hit = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    logic cand;
    logic better;
    always_comb begin
        if (r_rr) cand = (r_st[r_idx] == ST_READY) && (r_life[r_idx] != 16'd0);
        else cand = (r_idx != '0) && (r_st[r_idx] == ST_READY);
        better = 1'b1;
        if (r_found && !r_rr) begin
            case (t_policy'(i_policy))
                POL_PRIO: better = r_prio[r_idx] > r_prio[r_best];
                POL_SJF:  better = r_life[r_idx] < r_life[r_best];
                default:  better = 1'b0;
            endcase
        end
        if (r_found && r_rr) better = 1'b0;
    end

    logic [SW-1:0] next_idx;
    assign next_idx = (r_idx == SW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;

    assign o_status.kind = r_kind;
    assign o_status.tick_active = (r_count > CW'(1)) && (r_st[r_run] == ST_RUN);
    assign o_status.scan_done = (r_step == CW'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i < SLOTS; i++) r_st[i] <= ST_EMPTY;
            r_st[0] <= ST_RUN;
            r_life[0] <= 16'(MAIN_LIFETIME);
            r_prio[0] <= 8'(MAIN_PRIORITY);
            r_id[0] <= 8'd0;
            r_count <= CW'(1);
            r_run <= '0;
            r_done <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && !i_cmd.report) o_out_valid <= 1'b0;
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_tid <= i_new_tid;
                r_nlife <= i_new_lifetime;
                r_nprio <= i_new_priority;
            end
            if (i_cmd.scan_clear) begin
                r_from <= r_run;
                r_acc <= i_cmd.do_create && free_hit;
                r_ended <= 1'b0;
            end
            if (i_cmd.do_create && free_hit) begin
                r_st[free_idx] <= ST_READY;
                r_id[free_idx] <= r_tid;
                r_life[free_idx] <= r_nlife;
                r_prio[free_idx] <= r_nprio;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.do_tick) begin
                r_rr <= (t_policy'(i_policy) == POL_RR);
                r_found <= 1'b0;
                r_start_ok <= 1'b0;
                if (t_policy'(i_policy) == POL_RR) begin
                    r_idx <= (r_run == SW'(SLOTS - 1)) ? '0 : r_run + 1'b1;
                    r_step <= '0;
                    r_main_pick <= 1'b0;
                    r_term_other <= 1'b0;
                    if (r_run == '0) r_done <= 1'b0;
                    if (r_life[r_run] == 16'd0) begin
                        r_st[r_run] <= ST_TERM;
                        r_count <= r_count - 1'b1;
                        r_ended <= 1'b1;
                    end else begin
                        r_st[r_run] <= ST_READY;
                    end
                end else begin
                    r_idx <= '0;
                    r_main_pick <= (r_run == '0);
                    if (r_run == '0) begin
                        r_step <= '0;
                        r_term_other <= 1'b0;
                    end else if (r_life[r_run] != 16'd0) begin
                        r_life[r_run] <= r_life[r_run] - 1'b1;
                        r_step <= CW'(SLOTS);  // nothing to pick
                        r_term_other <= 1'b0;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_st[r_run] <= ST_TERM;
                        r_ended <= 1'b1;
                        r_term_other <= 1'b1;
                        r_step <= (r_count - 1'b1 <= CW'(1)) ? CW'(SLOTS) : '0;
                    end
                end
            end
            if (i_cmd.scan_step && (r_step != CW'(SLOTS))) begin
                if (cand && better) begin
                    r_found <= 1'b1;
                    r_best <= r_idx;
                end
                r_idx <= next_idx;
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.decide) begin
                r_start_ok <= r_found && (r_rr || r_main_pick || r_term_other);
                r_go_main <= !r_found && r_term_other;
                if (r_found && r_main_pick) r_st[0] <= ST_READY;
            end
            if (i_cmd.start) begin
                if (r_start_ok) begin
                    if (r_life[r_best] != 16'd0) r_life[r_best] <= r_life[r_best] - 1'b1;
                    r_st[r_best] <= ST_RUN;
                    r_run <= r_best;
                    if (r_rr && r_best == '0) r_done <= 1'b1;
                end else if (r_go_main) begin
                    r_st[0] <= ST_RUN;
                    r_run <= '0;
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.report) begin
                o_out_valid <= 1'b1;
                o_create_accepted <= r_acc;
                o_switched <= (r_run != r_from);
                o_from_main <= (r_from == '0);
                o_from_tid <= (r_from == '0) ? 8'd0 : r_id[r_from];
                o_to_main <= (r_run == '0);
                o_to_tid <= (r_run == '0) ? 8'd0 : r_id[r_run];
                o_ended_valid <= r_ended;
                o_ended_tid <= (r_ended && r_from != '0) ? r_id[r_from] : 8'd0;
                o_all_done <= r_done;
                o_live_count <= 5'(r_count);
            end
        end
    end
endmodule

/* rtl/thread_scheduler_four_policy.sv */
// Four-policy thread scheduler top level: controller plus slot datapath.
// Depends on tsfp_pkg, tsfp_if, tsfp_ctrl, tsfp_dp.
// Create: CREATE then REPORT; a tick that acts runs TICK, SCAN, DECIDE, START, then REPORT.
// One request at a time; a pick scans the slot table one slot per cycle.
// A new request is taken only once the last result is out; a stalled result holds off the next.
// Reset (synchronous, active low): slot 0 running as main, others empty, fifo policy.
`timescale 1ns / 1ps
module thread_scheduler_four_policy
    import tsfp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int MAIN_LIFETIME = MAIN_LIFETIME_DEF,
    parameter int MAIN_PRIORITY = MAIN_PRIORITY_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    tsfp_req_if.sink   req,
    tsfp_rsp_if.source rsp,
    tsfp_cfg_if.sink   cfg
);
    t_cmd    cmd;
    t_status status;
    logic [1:0] r_policy;
    logic out_free;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_policy <= 2'd0;
        else if (cfg.valid) r_policy <= cfg.data;
    end

    assign out_free = !rsp.valid || rsp.ready;

    tsfp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req.valid), .o_req_ready(req.ready),
        .i_out_free(out_free), .i_status(status), .o_cmd(cmd)
    );

    tsfp_dp #(.SLOTS(SLOTS), .MAIN_LIFETIME(MAIN_LIFETIME), .MAIN_PRIORITY(MAIN_PRIORITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_policy(r_policy), .i_kind(req.kind), .i_new_tid(req.new_tid),
        .i_new_lifetime(req.new_lifetime), .i_new_priority(req.new_priority),
        .i_out_ready(rsp.ready), .o_out_valid(rsp.valid),
        .o_create_accepted(rsp.create_accepted), .o_switched(rsp.switched),
        .o_from_main(rsp.from_main), .o_from_tid(rsp.from_tid), .o_to_main(rsp.to_main),
        .o_to_tid(rsp.to_tid), .o_ended_valid(rsp.ended_valid), .o_ended_tid(rsp.ended_tid),
        .o_all_done(rsp.all_done), .o_live_count(rsp.live_count)
    );
endmodule

/* rtl/tsfp_checker.sv */
// Port-level checker for the thread scheduler, bound to the top level.
// Depends on thread_scheduler_four_policy_defines.svh.
`timescale 1ns / 1ps
`include "thread_scheduler_four_policy_defines.svh"
module tsfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       create_accepted,
    input logic       switched,
    input logic       from_main,
    input logic       to_main,
    input logic [7:0] from_tid,
    input logic [7:0] to_tid,
    input logic       ended_valid
)
;
    `TS_ASSERT_IMP(a_create_quiet, i_clk, i_rst_n, rsp_valid && create_accepted, !switched && !ended_valid)
    `TS_ASSERT_IMP(a_main_tid, i_clk, i_rst_n, rsp_valid && to_main, to_tid == 8'd0)
    `TS_ASSERT_IMP(a_same_main, i_clk, i_rst_n, rsp_valid && !switched, from_main == to_main)
    `TS_ASSERT_NXT(a_one_req, i_clk, i_rst_n, req_valid && req_ready, !req_ready)
    `TS_ASSERT_NXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(from_tid))
endmodule

bind thread_scheduler_four_policy tsfp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .create_accepted(rsp.create_accepted),
    .switched(rsp.switched), .from_main(rsp.from_main), .to_main(rsp.to_main),
    .from_tid(rsp.from_tid), .to_tid(rsp.to_tid), .ended_valid(rsp.ended_valid)
);
